@@ hdl/rgbc_pkg.sv @@
// rgbc_pkg: widths, register indexes, kernel codes and kernel arithmetic
// for the rgb 3x3 convolution block; depends on nothing
package rgbc_pkg;

  localparam int CFG_W         = 13;
  localparam int CFG_ADDR_W    = 3;
  localparam int PIX_W         = 8;
  localparam int NUM_CH        = 3;
  localparam int RGB_W         = NUM_CH * PIX_W;
  localparam int KERNEL_DIM    = 3;
  localparam int WIN_N         = KERNEL_DIM * KERNEL_DIM;
  localparam int DEF_MAX_WIDTH = 4096;

  localparam int ACC_W       = 14;
  localparam int BOX_PROD_W  = 2 * ACC_W;
  localparam int BOX_RECIP   = 7282;
  localparam int BOX_SHIFT   = 17;
  localparam int GAUSS_SHIFT = 4;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd4096;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd4096;
  localparam logic [CFG_W-1:0] RST_SEL_LEFT     = 13'd0;
  localparam logic [CFG_W-1:0] RST_SEL_TOP      = 13'd0;
  localparam logic [CFG_W-1:0] RST_SEL_RIGHT    = 13'd4096;
  localparam logic [CFG_W-1:0] RST_SEL_BOTTOM   = 13'd4096;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL       = 3'd2,
    REG_SEL_LEFT     = 3'd3,
    REG_SEL_TOP      = 3'd4,
    REG_SEL_RIGHT    = 3'd5,
    REG_SEL_BOTTOM   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KERN_EDGE    = 2'd0,
    KERN_SHARPEN = 2'd1,
    KERN_BOX     = 2'd2,
    KERN_GAUSS   = 2'd3
  } kernel_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_ch_t;

  localparam pix_t PIX_MAX = 8'hFF;

  // weighted sum of one channel, bias included, before scaling and clamping
  function automatic acc_t kernel_acc(input kernel_t k, input win_ch_t v);
    acc_t c;
    acc_t s;
    acc_t x;
    acc_t g;
    acc_t r;
    c = acc_t'(v[4]);
    x = acc_t'(v[1]) + acc_t'(v[3]) + acc_t'(v[5]) + acc_t'(v[7]);
    s = acc_t'(v[0]) + acc_t'(v[2]) + acc_t'(v[6]) + acc_t'(v[8]) + x + c;
    g = acc_t'(v[0]) + acc_t'(v[2]) + acc_t'(v[6]) + acc_t'(v[8]) + (x <<< 1) + (c <<< 2);
    case (k)
      KERN_EDGE:    r = (c <<< 3) + c - s;
      KERN_SHARPEN: r = (c <<< 2) + c - x;
      KERN_BOX:     r = (s <<< 1) + acc_t'(9);
      default:      r = g + acc_t'(8);
    endcase
    return r;
  endfunction

  // box and gauss are scaled, edge and sharpen clamped; box divides by 18 through a reciprocal multiply
  function automatic pix_t kernel_out(input kernel_t k, input acc_t a);
    logic [BOX_PROD_W-1:0] p;
    pix_t r;
    p = BOX_PROD_W'($unsigned(a)) * BOX_PROD_W'(BOX_RECIP);
    case (k)
      KERN_BOX:   r = p[BOX_SHIFT +: PIX_W];
      KERN_GAUSS: r = a[GAUSS_SHIFT +: PIX_W];
      default: begin
        if (a < acc_t'(0)) begin
          r = '0;
        end else if (a > acc_t'(PIX_MAX)) begin
          r = PIX_MAX;
        end else begin
          r = a[PIX_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/rgbc_line_ram.sv @@
// rgbc_line_ram: one line store, one write port and two registered read ports
// with write-to-read forwarding; depends on rgbc_pkg for defaults
module rgbc_line_ram
  import rgbc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int DW    = RGB_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] q_a_r;
  logic [DW-1:0] q_b_r;
  logic [DW-1:0] wdata_r;
  logic          fwd_a_r;
  logic          fwd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    q_a_r   <= mem_r[raddr_a];
    q_b_r   <= mem_r[raddr_b];
    wdata_r <= wdata;
  end

  // a read of the entry written in the same cycle takes the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
    end else begin
      fwd_a_r <= we && (waddr == raddr_a);
      fwd_b_r <= we && (waddr == raddr_b);
    end
  end

  assign rdata_a = fwd_a_r ? wdata_r : q_a_r;
  assign rdata_b = fwd_b_r ? wdata_r : q_b_r;

endmodule

@@ hdl/rgb_convolution_3x3.sv @@
// rgb_convolution_3x3: line-buffered 3x3 rgb filter; depends on rgbc_pkg, rgbc_line_ram
// throughput one item per clock while in_tready is high (no clear, output not stalled);
// a result passes the stage 1 and output registers after the item that pushes it out;
// results trail their pixels by image_width + 1 items; line store reads are prefetched
// at the next column, so the registered ram read is hidden; sync active-low reset loads
// default registers, then zeroes both line stores with in_tready low
module rgb_convolution_3x3
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [RGB_W-1:0]      in_tdata,   // in_red, in_green, in_blue
  input  logic                  in_tuser,   // drain
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [RGB_W-1:0]      out_tdata,  // out_red, out_green, out_blue
  output logic                  out_tlast,  // frame_last
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int CW = WW + 1;
  localparam int RW = CFG_W + 1;
  localparam int PW = WW + 1;

  // configuration
  logic [CFG_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [CFG_W-1:0] left_r, left_nxt, top_r, top_nxt;
  logic [CFG_W-1:0] right_r, right_nxt, bottom_r, bottom_nxt;
  kernel_t          kernel_r, kernel_nxt;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    kernel_nxt = kernel_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        REG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        REG_KERNEL:       kernel_nxt = kernel_t'(cfg_wdata[1:0]);
        REG_SEL_LEFT:     left_nxt   = cfg_wdata;
        REG_SEL_TOP:      top_nxt    = cfg_wdata;
        REG_SEL_RIGHT:    right_nxt  = cfg_wdata;
        REG_SEL_BOTTOM:   bottom_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      kernel_r <= KERN_EDGE;
      left_r   <= RST_SEL_LEFT;
      top_r    <= RST_SEL_TOP;
      right_r  <= RST_SEL_RIGHT;
      bottom_r <= RST_SEL_BOTTOM;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      kernel_r <= kernel_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  function automatic logic [WW-1:0] eff_width(input logic [CFG_W-1:0] c);
    if (c == '0) begin
      return WW'(1);
    end
    if (WW'(c) > WW'(MAX_WIDTH)) begin
      return WW'(MAX_WIDTH);
    end
    return WW'(c);
  endfunction

  logic [WW-1:0]    width_eff, width_eff_nxt;
  logic [CFG_W-1:0] height_eff;

  assign width_eff     = eff_width(width_r);
  assign width_eff_nxt = eff_width(width_nxt);
  assign height_eff    = (height_r == '0) ? CFG_W'(1) : height_r;

  // position counters and pending count
  logic [AW-1:0]    ci_r, ci_nxt, oc_r, oc_nxt, ci_w, oc_w;
  logic [CFG_W-1:0] ir_r, ir_nxt, or_r, or_nxt, ir_w, or_w;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [WW-1:0]    ci_inc, oc_inc;
  logic [RW-1:0]    ir_inc, or_inc;

  assign ci_w   = (WW'(ci_r) >= width_eff) ? '0 : ci_r;
  assign oc_w   = (WW'(oc_r) >= width_eff) ? '0 : oc_r;
  assign ir_w   = (ir_r >= height_eff) ? '0 : ir_r;
  assign or_w   = (or_r >= height_eff) ? '0 : or_r;
  assign ci_inc = WW'(ci_w) + WW'(1);
  assign oc_inc = WW'(oc_w) + WW'(1);
  assign ir_inc = RW'(ir_w) + RW'(1);
  assign or_inc = RW'(or_w) + RW'(1);

  // handshake and clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;
  logic          s1_valid_r, s1_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_adv, s1_adv, accept, pix_acc, pend_gt_w, emit;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_adv;
  assign in_tready = !clr_busy_r && (!s1_valid_r || out_adv);
  assign accept    = in_tvalid && in_tready;
  assign pix_acc   = accept && !in_tuser;
  assign pend_gt_w = pend_r > PW'(width_eff);
  assign emit      = accept && (in_tuser ? (pend_r != '0) : pend_gt_w);

  always_comb begin
    ci_nxt   = ci_r;
    ir_nxt   = ir_r;
    oc_nxt   = oc_r;
    or_nxt   = or_r;
    pend_nxt = pend_r;
    if (accept) begin
      ci_nxt = ci_w;
      ir_nxt = ir_w;
      oc_nxt = oc_w;
      or_nxt = or_w;
      if (!in_tuser) begin
        if (ci_inc >= width_eff) begin
          ci_nxt = '0;
          ir_nxt = (ir_inc >= RW'(height_eff)) ? '0 : ir_inc[CFG_W-1:0];
        end else begin
          ci_nxt = ci_inc[AW-1:0];
        end
        pend_nxt = pend_gt_w ? PW'(width_eff) + PW'(1) : pend_r + PW'(1);
      end else if (pend_r != '0) begin
        pend_nxt = pend_r - PW'(1);
      end
      if (emit) begin
        if (oc_inc >= width_eff) begin
          oc_nxt = '0;
          or_nxt = (or_inc >= RW'(height_eff)) ? '0 : or_inc[CFG_W-1:0];
        end else begin
          oc_nxt = oc_inc[AW-1:0];
        end
      end
    end
  end

  assign s1_valid_nxt  = (accept && emit) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r        <= '0;
      oc_r        <= '0;
      ir_r        <= '0;
      or_r        <= '0;
      pend_r      <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ci_r        <= ci_nxt;
      oc_r        <= oc_nxt;
      ir_r        <= ir_nxt;
      or_r        <= or_nxt;
      pend_r      <= pend_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // line stores: port a at the input column, port b at the output column
  logic [AW-1:0]    rd_ci_addr, rd_oc_addr, wr_addr;
  logic [RGB_W-1:0] up_ci, up_oc, md_ci, md_oc, up_wdata, md_wdata;
  logic             mem_we;

  assign rd_ci_addr = (WW'(ci_nxt) >= width_eff_nxt) ? '0 : ci_nxt;
  assign rd_oc_addr = (WW'(oc_nxt) >= width_eff_nxt) ? '0 : oc_nxt;
  assign mem_we     = clr_busy_r || pix_acc;
  assign wr_addr    = clr_busy_r ? clr_cnt_r : ci_w;
  assign up_wdata   = clr_busy_r ? '0 : md_ci;
  assign md_wdata   = clr_busy_r ? '0 : in_tdata;

  rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DW(RGB_W)) u_upper (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .waddr   (wr_addr),
    .wdata   (up_wdata),
    .raddr_a (rd_ci_addr),
    .raddr_b (rd_oc_addr),
    .rdata_a (up_ci),
    .rdata_b (up_oc)
  );

  rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DW(RGB_W)) u_middle (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (mem_we),
    .waddr   (wr_addr),
    .wdata   (md_wdata),
    .raddr_a (rd_ci_addr),
    .raddr_b (rd_oc_addr),
    .rdata_a (md_ci),
    .rdata_b (md_oc)
  );

  // 3x3 window
  logic [WIN_N-1:0][RGB_W-1:0] win_r, win_nxt;

  always_comb begin
    win_nxt = win_r;
    if (pix_acc) begin
      for (int r = 0; r < KERNEL_DIM; r++) begin
        win_nxt[r*KERNEL_DIM]     = win_r[r*KERNEL_DIM + 1];
        win_nxt[r*KERNEL_DIM + 1] = win_r[r*KERNEL_DIM + 2];
      end
      win_nxt[KERNEL_DIM - 1]     = up_ci;
      win_nxt[2*KERNEL_DIM - 1]   = md_ci;
      win_nxt[WIN_N - 1]          = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  // selection rectangle shrunk away from the border
  logic [WW-1:0]    right_c;
  logic [CFG_W-1:0] bottom_c;
  logic [RW-1:0]    rb, re;
  logic [CW-1:0]    cb, ce;
  logic             reg_en, in_region;

  assign right_c  = (WW'(right_r) > width_eff) ? width_eff : WW'(right_r);
  assign bottom_c = (bottom_r > height_eff) ? height_eff : bottom_r;
  assign rb = (top_r == '0) ? RW'(1) : RW'(top_r);
  assign re = (bottom_c == height_eff) ? RW'(height_eff) - RW'(1) : RW'(bottom_c);
  assign cb = (left_r == '0) ? CW'(1) : CW'(left_r);
  assign ce = (right_c == width_eff) ? CW'(width_eff) - CW'(1) : CW'(right_c);
  assign reg_en = (rb + RW'(1) < re) && (cb + CW'(1) < ce);
  assign in_region = reg_en && (RW'(or_w) >= rb) && (RW'(or_w) < re)
                     && (CW'(oc_w) >= cb) && (CW'(oc_w) < ce);

  // stage 1: kernel sums and pass-through pixel
  acc_t             acc_nxt [NUM_CH];
  acc_t             s1_acc_r [NUM_CH];
  logic [RGB_W-1:0] s1_pix_r;
  logic             s1_filt_r, s1_last_r;
  kernel_t          s1_kern_r;
  logic             frame_last;
  logic [RGB_W-1:0] pass_pix;
  logic [NUM_CH-1:0][PIX_W-1:0] out_ch_nxt;
  logic [RGB_W-1:0] out_data_r;
  logic             out_last_r;

  assign frame_last = (or_w == height_eff - CFG_W'(1)) && (WW'(oc_w) == width_eff - WW'(1));
  assign pass_pix   = (in_tuser && !pend_gt_w) ? md_oc : up_oc;

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    win_ch_t chv;
    always_comb begin
      for (int k = 0; k < WIN_N; k++) begin
        chv[k] = win_nxt[k][ch*PIX_W +: PIX_W];
      end
    end
    assign acc_nxt[ch]    = kernel_acc(kernel_r, chv);
    assign out_ch_nxt[ch] = s1_filt_r ? kernel_out(s1_kern_r, s1_acc_r[ch])
                                      : s1_pix_r[ch*PIX_W +: PIX_W];
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_acc_r  <= acc_nxt;
      s1_pix_r  <= pass_pix;
      s1_filt_r <= pix_acc && in_region;
      s1_last_r <= frame_last;
      s1_kern_r <= kernel_r;
    end
    if (s1_adv) begin
      out_data_r <= out_ch_nxt;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/rgbc_checker.sv @@
// rgbc_checker: port-level checks for rgb_convolution_3x3, bound to the top level
// depends on rgbc_pkg for the data width
module rgbc_checker
  import rgbc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [RGB_W-1:0] out_tdata,
  input logic             out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset starts the line store clear, so no item is taken right after
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken during line store clear");

  // a result shows up only after an accepted item has passed stage 1 and the output register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching item");

endmodule

bind rgb_convolution_3x3 rgbc_checker u_rgbc_checker (.*);

@@ bench/rgbc_stream_checker.sv @@
// rgbc_stream_checker: watches the pixel, result and register ports of rgb_convolution_3x3,
// keeps its own line stores and window, predicts every output item and compares field by field
// depends on rgbc_pkg
module rgbc_stream_checker
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [RGB_W-1:0]      in_tdata,   // in_red, in_green, in_blue
  input  logic                  in_tuser,   // drain
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [RGB_W-1:0]      out_tdata,  // out_red, out_green, out_blue
  input  logic                  out_tlast,  // frame_last
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    mismatches,
  output int                    results_due
);

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic last;
  } rgb_out_t;

  int      width_reg, height_reg, left_reg, top_reg, right_reg, bottom_reg;
  kernel_t kern;

  // pixels held as {red, green, blue}
  logic [RGB_W-1:0] upper_line  [MAX_WIDTH];
  logic [RGB_W-1:0] middle_line [MAX_WIDTH];
  logic [RGB_W-1:0] win         [WIN_N];
  int               in_col, in_row, out_col, out_row, held, errs;
  rgb_out_t         due_pixels [$];

  function automatic pix_t conv_channel(int sh);
    int v [WIN_N];
    int s;
    int acc;
    int k;
    s = 0;
    for (k = 0; k < WIN_N; k++) begin
      v[k] = int'(win[k][sh +: PIX_W]);
      s += v[k];
    end
    case (kern)
      KERN_EDGE:    acc = 9 * v[4] - s;
      KERN_SHARPEN: acc = 5 * v[4] - v[1] - v[3] - v[5] - v[7];
      KERN_BOX:     acc = (2 * s + 9) / 18;
      default:      acc = (v[0] + 2 * v[1] + v[2] + 2 * v[3] + 4 * v[4] + 2 * v[5]
                           + v[6] + 2 * v[7] + v[8] + 8) / 16;
    endcase
    if (acc < 0) return '0;
    if (acc > int'(PIX_MAX)) return PIX_MAX;
    return pix_t'(acc);
  endfunction

  // selection shrunk away from the border; empty when one line or column thin
  function automatic bit in_filter_region(int r, int c, int w, int h);
    int rgt, btm, rb, re, cb, ce;
    rgt = (right_reg > w) ? w : right_reg;
    btm = (bottom_reg > h) ? h : bottom_reg;
    rb  = (top_reg == 0) ? 1 : top_reg;
    re  = (btm == h) ? h - 1 : btm;
    cb  = (left_reg == 0) ? 1 : left_reg;
    ce  = (rgt == w) ? w - 1 : rgt;
    if (rb >= re - 1 || cb >= ce - 1) return 1'b0;
    return r >= rb && r < re && c >= cb && c < ce;
  endfunction

  function automatic void emit_pixel(logic [RGB_W-1:0] rgb, int w, int h);
    rgb_out_t res;
    res.red   = rgb[23:16];
    res.green = rgb[15:8];
    res.blue  = rgb[7:0];
    res.last  = (out_row == h - 1) && (out_col == w - 1);
    due_pixels.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
  endfunction

  task automatic step_window(logic [RGB_W-1:0] rgb, bit drain);
    int               w, h, ci, r;
    logic [RGB_W-1:0] delayed;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    if (in_col >= w) in_col = 0;
    if (in_row >= h) in_row = 0;
    if (out_col >= w) out_col = 0;
    if (out_row >= h) out_row = 0;
    if (drain) begin
      if (held == 0) return;
      emit_pixel(held > w ? upper_line[out_col] : middle_line[out_col], w, h);
      held--;
      return;
    end
    ci = in_col;
    delayed = upper_line[out_col];
    for (r = 0; r < KERNEL_DIM; r++) begin
      win[r * 3]     = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = upper_line[ci];
    win[5] = middle_line[ci];
    win[8] = rgb;
    upper_line[ci]  = middle_line[ci];
    middle_line[ci] = rgb;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    held++;
    if (held <= w + 1) return;
    held = w + 1;
    if (in_filter_region(out_row, out_col, w, h))
      delayed = {conv_channel(16), conv_channel(8), conv_channel(0)};
    emit_pixel(delayed, w, h);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rgb_out_t want;
    int       k;
    if (!rst_n) begin
      for (k = 0; k < MAX_WIDTH; k++) begin
        upper_line[k]  = '0;
        middle_line[k] = '0;
      end
      for (k = 0; k < WIN_N; k++) win[k] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      held = 0;
      due_pixels.delete();
      width_reg  = int'(RST_IMAGE_WIDTH);
      height_reg = int'(RST_IMAGE_HEIGHT);
      kern       = KERN_EDGE;
      left_reg   = int'(RST_SEL_LEFT);
      top_reg    = int'(RST_SEL_TOP);
      right_reg  = int'(RST_SEL_RIGHT);
      bottom_reg = int'(RST_SEL_BOTTOM);
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  = int'(cfg_wdata);
          REG_IMAGE_HEIGHT: height_reg = int'(cfg_wdata);
          REG_KERNEL:       kern       = kernel_t'(cfg_wdata[1:0]);
          REG_SEL_LEFT:     left_reg   = int'(cfg_wdata);
          REG_SEL_TOP:      top_reg    = int'(cfg_wdata);
          REG_SEL_RIGHT:    right_reg  = int'(cfg_wdata);
          REG_SEL_BOTTOM:   bottom_reg = int'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        step_window({in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}, in_tuser);
      if (out_tvalid && out_tready) begin
        if (due_pixels.size() == 0) begin
          errs++;
          $display("%0t: output item with none expected, expected nothing, actual %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = due_pixels.pop_front();
          check_field("red", want.red, out_tdata[7:0]);
          check_field("green", want.green, out_tdata[15:8]);
          check_field("blue", want.blue, out_tdata[23:16]);
          check_field("frame_last", want.last, out_tlast);
        end
      end
    end
    mismatches  <= errs;
    results_due <= due_pixels.size();
  end

endmodule

@@ bench/tb.sv @@
// tb: stimulus and verdict for rgb_convolution_3x3; raster frames, drains and register
// phases with random idling on both sides; depends on rgbc_pkg and rgbc_stream_checker
module tb;
  import rgbc_pkg::*;

  localparam int LIMIT     = 500000;
  localparam int SETTLE    = 8;
  localparam int RUN_ITEMS = 1050;
  localparam int RUN_CAP   = 60;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [RGB_W-1:0]      in_tdata   = '0;  // in_red, in_green, in_blue
  logic                  in_tuser   = 1'b0;  // drain
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RGB_W-1:0]      out_tdata;  // out_red, out_green, out_blue
  logic                  out_tlast;  // frame_last
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  int mismatches;
  int results_due;
  int cycles;
  bit steady;
  int backlog, items;

  rgb_convolution_3x3 u_dut (.*);

  rgbc_stream_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 17);
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // rgb is {red, green, blue}
  task automatic push_item(logic [RGB_W-1:0] rgb, bit drain);
    if (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
    in_tuser  <= drain;
    items++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int w, int h, kernel_t k, int l, int t, int r, int b);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_KERNEL, int'(k));
    set_reg(REG_SEL_LEFT, l);
    set_reg(REG_SEL_TOP, t);
    set_reg(REG_SEL_RIGHT, r);
    set_reg(REG_SEL_BOTTOM, b);
  endtask

  function automatic logic [RGB_W-1:0] pick_rgb(bit harsh);
    logic [RGB_W-1:0] v;
    v = RGB_W'($urandom);
    if (harsh) begin
      v[23:16] = $urandom_range(1) ? PIX_MAX : 8'h00;
      v[15:8]  = $urandom_range(1) ? PIX_MAX : 8'h00;
      v[7:0]   = $urandom_range(1) ? PIX_MAX : 8'h00;
    end
    return v;
  endfunction

  task automatic run_pixels(int n, bit noisy, bit harsh);
    int i;
    for (i = 0; i < n; i++) begin
      if (noisy && $urandom_range(99) < 10) push_item(pick_rgb(1'b0), 1'b1);
      push_item(pick_rgb(harsh), 1'b0);
      backlog++;
    end
  endtask

  task automatic flush();
    repeat ((backlog > DEF_MAX_WIDTH + 1) ? DEF_MAX_WIDTH + 1 : backlog)
      push_item(pick_rgb(1'b0), 1'b1);
    backlog = 0;
  endtask

  initial begin
    int      i, phase, first, n, w_reg, h_reg, ew, eh, l, t, r, b;
    kernel_t k;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drains with nothing pending, then a 4x4 edge frame of saturated checkerboard with a drain mid-frame
    push_item(24'hFFFFFF, 1'b1);
    push_item(24'h000000, 1'b1);
    settle();
    configure(4, 4, KERN_EDGE, 0, 0, 4, 4);
    for (i = 0; i < 16; i++) begin
      if (i == 9) push_item(24'h123456, 1'b1);
      push_item(((i + i / 4) % 2) ? 24'hFF00FF : 24'h00FF00, 1'b0);
    end
    backlog = 16;
    flush();
    settle();
    set_reg(REG_UNUSED, 13'h1FFF);

    phase = 0;
    first = items;
    while (items - first < RUN_ITEMS) begin
      phase++;
      steady = (phase >= 5 && phase < 9);
      if (phase == 1) begin
        w_reg = 8191;
        h_reg = 3;
      end else if (phase == 2) begin
        w_reg = 5;
        h_reg = 8191;
      end else begin
        case ($urandom_range(9))
          0:       w_reg = 0;
          1:       w_reg = 1;
          2:       w_reg = 2;
          3:       w_reg = $urandom_range(11, 40);
          default: w_reg = $urandom_range(3, 10);
        endcase
        h_reg = $urandom_range(0, 8);
      end
      ew = (w_reg == 0) ? 1 : ((w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_reg);
      eh = (h_reg == 0) ? 1 : h_reg;
      k = (phase <= 4) ? kernel_t'(phase - 1) : kernel_t'($urandom_range(3));
      case ($urandom_range(5))
        0, 1: begin
          l = 0;
          t = 0;
          r = ew;
          b = eh;
        end
        2: begin
          l = 0;
          t = 0;
          r = $urandom_range(ew, 8191);
          b = $urandom_range(eh, 8191);
        end
        3: begin
          l = 8191;
          t = 8191;
          r = 0;
          b = 0;
        end
        default: begin
          l = $urandom_range(0, ew + 1);
          t = $urandom_range(0, eh + 1);
          r = $urandom_range(0, ew + 2);
          b = $urandom_range(0, eh + 2);
        end
      endcase
      configure(w_reg, h_reg, k, l, t, r, b);
      n = ew * eh * $urandom_range(1, 3);
      if (n > RUN_CAP) n = RUN_CAP;
      if ($urandom_range(99) < 15) n = $urandom_range(1, n);
      run_pixels(n, $urandom_range(99) < 25, $urandom_range(99) < 20);
      if ($urandom_range(99) < 80) flush();
      settle();
    end
    steady = 1'b0;
    flush();
    settle();

    if (mismatches == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
